[rtl/psr_pkg.sv]
// ----------------------------------------------------------------------------
// psr_pkg
// Shared widths, multiplier step codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int MAX_PARTICLES = 1048576;
  localparam int CNT_W         = 21;
  localparam logic [CNT_W-1:0] CNT_FIELD_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_PARTICLES < (2**CNT_W - 1)) ? CNT_W'(MAX_PARTICLES) : CNT_FIELD_MAX;

  localparam int IN_W  = 264;
  localparam int OUT_W = 440;
  localparam int CFG_IDX_W = 3;

  localparam logic [62:0] U63_MAX = {63{1'b1}};

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd4;

  // shared multiplier steps
  localparam logic [3:0] OP_VX2    = 4'd0;
  localparam logic [3:0] OP_VY2    = 4'd1;
  localparam logic [3:0] OP_VZ2    = 4'd2;
  localparam logic [3:0] OP_MASS   = 4'd3;
  localparam logic [3:0] OP_DX2    = 4'd4;
  localparam logic [3:0] OP_DY2    = 4'd5;
  localparam logic [3:0] OP_DZ2    = 4'd6;
  localparam logic [3:0] OP_RAD2   = 4'd7;
  localparam logic [3:0] OP_KE_LL  = 4'd8;
  localparam logic [3:0] OP_KE_LH  = 4'd9;
  localparam logic [3:0] OP_KE_HL  = 4'd10;
  localparam logic [3:0] OP_KE_HH  = 4'd11;
  localparam logic [3:0] OP_LAST   = OP_KE_HH;

  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic       load;
    logic       op_en;
    logic [3:0] op;
    logic       acc;
    logic       sq_init;
    logic       sq_step;
    logic       emit;
  } psr_cmd_t;

  typedef struct packed {
    logic included;
    logic last;
    logic out_full;
  } psr_sts_t;

endpackage

[rtl/psr_ctrl.sv]
// ----------------------------------------------------------------------------
// psr_ctrl
// Sequencer: load, multiplier steps, accumulate, square root, result.
// ----------------------------------------------------------------------------
module psr_ctrl import psr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  psr_sts_t sts,
  output psr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_ACC    = 3'd4;
  localparam logic [2:0] S_SQINIT = 3'd5;
  localparam logic [2:0] S_SQRT   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state, state_next;
  logic [4:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        step_next = '0;
        if (sts.included) state_next = S_MUL;
        else if (sts.last) state_next = S_SQINIT;
        else state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.op_en = 1'b1;
        cmd.op    = step[3:0];
        step_next = step + 5'd1;
        if (step[3:0] == OP_LAST) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_ACC;
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? S_SQINIT : S_IDLE;
      end
      S_SQINIT: begin
        cmd.sq_init = 1'b1;
        step_next   = '0;
        state_next  = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        step_next   = step + 5'd1;
        if (step == 5'(SQRT_STEPS - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        // wait until the previous result has been taken
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

[rtl/psr_dp.sv]
// ----------------------------------------------------------------------------
// psr_dp
// Datapath: config registers, shared 32x32 multiplier, saturating sums,
// bit-serial square root and the result register.
// ----------------------------------------------------------------------------
module psr_dp import psr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [IN_W-1:0]      in_data,
  input  logic                 in_last,
  input  psr_cmd_t             cmd,
  output psr_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_data
);

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    absdiff = d[32] ? 32'(~d + 33'd1) : d[31:0];
  endfunction

  function automatic logic [63:0] sat_s(input logic [63:0] acc, input logic [31:0] v);
    logic [64:0] s;
    s = {acc[63], acc} + {{33{v[31]}}, v};
    if (s[64] != s[63]) sat_s = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_s = s[63:0];
  endfunction

  function automatic logic [62:0] sat_u(input logic [62:0] acc, input logic [62:0] v);
    logic [63:0] s;
    s = {1'b0, acc} + {1'b0, v};
    sat_u = s[63] ? U63_MAX : s[62:0];
  endfunction

  logic [31:0] type_mask, center_x, center_y, center_z, radius;

  logic [5:0]  ptype;
  logic        last;
  logic [31:0] ax, ay, az, dx, dy, dz, dens, vfr;
  logic [31:0] vx, vy, vz;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic         op_v_d;
  logic [3:0]   op_d;
  logic [63:0]  vsq, mf, rsq;
  logic [65:0]  dsq;
  logic [127:0] ke;

  logic [CNT_W-1:0] count_acc;
  logic [63:0] vx_acc, vy_acc, vz_acc;
  logic [62:0] volume_acc, mass_acc, energy_acc;
  logic [63:0] peak_sq;

  logic [63:0] sq_v;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [33:0] rem_sh, trial;
  logic [62:0] ke_term;
  logic [4:0]  tidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask <= '1;
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
      radius    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TYPE_MASK: type_mask <= cfg_data;
        REG_CENTER_X:  center_x  <= cfg_data;
        REG_CENTER_Y:  center_y  <= cfg_data;
        REG_CENTER_Z:  center_z  <= cfg_data;
        REG_RADIUS:    radius    <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptype <= in_data[5:0];
      vx    <= in_data[37:6];
      vy    <= in_data[69:38];
      vz    <= in_data[101:70];
      ax    <= abs32(in_data[37:6]);
      ay    <= abs32(in_data[69:38]);
      az    <= abs32(in_data[101:70]);
      dens  <= in_data[133:102];
      vfr   <= in_data[165:134];
      dx    <= absdiff(in_data[197:166], center_x);
      dy    <= absdiff(in_data[229:198], center_y);
      dz    <= absdiff(in_data[261:230], center_z);
      last  <= in_last;
    end
  end

  assign tidx = 5'(ptype - 6'd1);
  assign sts.included = (ptype >= 6'd1) && (ptype <= 6'd32) && type_mask[tidx];
  assign sts.last     = last;
  assign sts.out_full = out_valid;

  always_comb begin
    case (cmd.op)
      OP_VX2:   begin mul_a = ax;        mul_b = ax;         end
      OP_VY2:   begin mul_a = ay;        mul_b = ay;         end
      OP_VZ2:   begin mul_a = az;        mul_b = az;         end
      OP_MASS:  begin mul_a = dens;      mul_b = vfr;        end
      OP_DX2:   begin mul_a = dx;        mul_b = dx;         end
      OP_DY2:   begin mul_a = dy;        mul_b = dy;         end
      OP_DZ2:   begin mul_a = dz;        mul_b = dz;         end
      OP_RAD2:  begin mul_a = radius;    mul_b = radius;     end
      OP_KE_LL: begin mul_a = mf[31:0];  mul_b = vsq[31:0];  end
      OP_KE_LH: begin mul_a = mf[31:0];  mul_b = vsq[63:32]; end
      OP_KE_HL: begin mul_a = mf[63:32]; mul_b = vsq[31:0];  end
      OP_KE_HH: begin mul_a = mf[63:32]; mul_b = vsq[63:32]; end
      default:  begin mul_a = '0;        mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) op_v_d <= 1'b0;
    else op_v_d <= cmd.op_en;
    op_d <= cmd.op;
    prod <= mul_a * mul_b;
  end

  // product registered, consumed in the cycle after its step
  always_ff @(posedge clk) begin
    if (op_v_d) begin
      case (op_d)
        OP_VX2:   vsq <= prod;
        OP_VY2,
        OP_VZ2:   vsq <= vsq + prod;
        OP_MASS:  mf  <= prod;
        OP_DX2:   dsq <= {2'b00, prod};
        OP_DY2,
        OP_DZ2:   dsq <= dsq + {2'b00, prod};
        OP_RAD2:  rsq <= prod;
        OP_KE_LL: ke  <= {64'd0, prod};
        OP_KE_LH,
        OP_KE_HL: ke  <= ke + {32'd0, prod, 32'd0};
        OP_KE_HH: ke  <= ke + {prod, 64'd0};
        default: ;
      endcase
    end
  end

  assign ke_term = (ke[127:112] != 16'd0) ? U63_MAX : ke[111:49];

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count_acc  <= '0;
      vx_acc     <= '0;
      vy_acc     <= '0;
      vz_acc     <= '0;
      volume_acc <= '0;
      mass_acc   <= '0;
      energy_acc <= '0;
      peak_sq    <= '0;
    end else if (cmd.acc) begin
      vx_acc     <= sat_s(vx_acc, vx);
      vy_acc     <= sat_s(vy_acc, vy);
      vz_acc     <= sat_s(vz_acc, vz);
      volume_acc <= sat_u(volume_acc, {31'd0, vfr});
      mass_acc   <= sat_u(mass_acc, {15'd0, mf[63:16]});
      energy_acc <= sat_u(energy_acc, ke_term);
      if (count_acc < CNT_CAP) count_acc <= count_acc + 1'b1;
      if (radius != 32'd0 && dsq <= {2'b00, rsq} && vsq > peak_sq) peak_sq <= vsq;
    end
  end

  // restoring square root, one result bit per step
  assign rem_sh = {sq_rem[31:0], sq_v[63:62]};
  assign trial  = {sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_v    <= peak_sq;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sq_step) begin
      sq_v <= {sq_v[61:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem  <= rem_sh - trial;
        sq_root <= {sq_root[30:0], 1'b1};
      end else begin
        sq_rem  <= rem_sh;
        sq_root <= {sq_root[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {6'd0, sq_root, energy_acc, mass_acc, volume_acc,
                   vz_acc, vy_acc, vx_acc, count_acc};
    end
  end

endmodule

[rtl/particle_stats_reducer.sv]
// ----------------------------------------------------------------------------
// particle_stats_reducer
// Reduces a particle stream to counts, saturated sums and peak speed.
// ----------------------------------------------------------------------------
// Input channel s_axis: one particle per transfer, tlast ends the set.
// Output channel m_axis: one result per set, sent after the last particle.
// Config port: cfg_we/cfg_index/cfg_data writes type mask, sphere centre
// and radius; write only while the block is idle.
// Sequence: a particle whose type is masked out is only loaded and decided;
// an included particle makes twelve passes through the single 32x32
// multiplier, then a drain and an accumulate step. A last item adds the
// one-bit-per-cycle square root of the peak, then the result is loaded
// into the output register.
// The output register holds a result while m_axis_tready is low; the
// block keeps accepting particles meanwhile and only stalls when a second
// result is ready before the first is taken.
// Reset clears all sums, sets the type mask to all ones, centre and
// radius to zero (peak tracking off).
// ----------------------------------------------------------------------------
module particle_stats_reducer import psr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // particle_type, vel_x, vel_y, vel_z, density, volume_fraction,
  // pos_x, pos_y, pos_z
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // particle_count, sum_vel_x, sum_vel_y, sum_vel_z, total_volume,
  // total_mass, kinetic_energy, peak_speed
  output logic [OUT_W-1:0]     m_axis_tdata
);

  psr_cmd_t cmd;
  psr_sts_t sts;

  psr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !m_axis_tvalid) else $error("result overwritten");

  a_mul_included: assert property (@(posedge clk) disable iff (rst)
    cmd.op_en |-> sts.included) else $error("excluded particle multiplied");

  a_sqrt_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_init |-> sts.last) else $error("result without last");

endmodule

[tb/sv/psr_checker.sv]
// ----------------------------------------------------------------------------
// psr_checker
// Mirrors the register writes and the particle stream, predicts the totals
// of every set and compares them with the results on m_axis.
// ----------------------------------------------------------------------------
module psr_checker import psr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OUT_W-1:0]     m_axis_tdata,
  output int                   fails,
  output int                   pending,
  output int                   results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CNT_W-1:0]   count;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
    logic [62:0]        volume;
    logic [62:0]        mass;
    logic [62:0]        energy;
    logic [31:0]        peak;
  } set_totals_t;

  set_totals_t totals_q[$];

  logic [31:0]        mask_r, cx_r, cy_r, cz_r, radius_r;
  logic [CNT_W-1:0]   count_sum;
  logic signed [63:0] vx_sum, vy_sum, vz_sum;
  logic [62:0]        volume_sum, mass_sum, energy_sum;
  logic [63:0]        peak_sq;
  int                 fail_cnt;
  int                 result_cnt;

  function automatic logic signed [63:0] add_clamp_s(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63])
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [62:0] add_clamp_u(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? U63_MAX : s[62:0];
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // floor square root, one result bit per pass from the top
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (32'd1 << i);
      if ({32'd0, c} * {32'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] square32(logic [63:0] v);
    return v * v;
  endfunction

  task automatic clear_sums();
    count_sum = '0;
    vx_sum = '0; vy_sum = '0; vz_sum = '0;
    volume_sum = '0; mass_sum = '0; energy_sum = '0;
    peak_sq = '0;
  endtask

  task automatic take_particle(logic [IN_W-1:0] d, logic last);
    logic [5:0]         ptype;
    logic signed [63:0] vx, vy, vz, px, py, pz;
    logic [31:0]        dens, vfr;
    logic [63:0]        vsq, mass_full;
    logic [127:0]       prod;
    logic [62:0]        ke;
    logic [65:0]        dist_sq;
    logic               included;
    set_totals_t        t;
    ptype = d[5:0];
    vx = $signed(d[37:6]);
    vy = $signed(d[69:38]);
    vz = $signed(d[101:70]);
    dens = d[133:102];
    vfr = d[165:134];
    px = $signed(d[197:166]);
    py = $signed(d[229:198]);
    pz = $signed(d[261:230]);
    included = 1'b0;
    if (ptype >= 1 && ptype <= 32) included = mask_r[ptype - 1];
    if (included) begin
      vsq = square32(abs64(vx)) + square32(abs64(vy)) + square32(abs64(vz));
      mass_full = {32'd0, dens} * {32'd0, vfr};
      prod = {64'd0, mass_full} * {64'd0, vsq};
      ke = (prod[127:112] != 0) ? U63_MAX : prod[111:49];
      vx_sum = add_clamp_s(vx_sum, vx);
      vy_sum = add_clamp_s(vy_sum, vy);
      vz_sum = add_clamp_s(vz_sum, vz);
      volume_sum = add_clamp_u(volume_sum, {31'd0, vfr});
      mass_sum = add_clamp_u(mass_sum, {15'd0, mass_full[63:16]});
      energy_sum = add_clamp_u(energy_sum, ke);
      if (count_sum < CNT_CAP) count_sum++;
      if (radius_r != 0) begin
        dist_sq = {2'b0, square32(abs64(px - $signed(cx_r)))}
                + {2'b0, square32(abs64(py - $signed(cy_r)))}
                + {2'b0, square32(abs64(pz - $signed(cz_r)))};
        if (dist_sq <= {2'b0, {32'd0, radius_r} * {32'd0, radius_r}} && vsq > peak_sq)
          peak_sq = vsq;
      end
    end
    if (last) begin
      t.count = count_sum;
      t.vx = vx_sum; t.vy = vy_sum; t.vz = vz_sum;
      t.volume = volume_sum; t.mass = mass_sum; t.energy = energy_sum;
      t.peak = floor_sqrt(peak_sq);
      totals_q.push_back(t);
      clear_sums();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(logic [OUT_W-1:0] d);
    set_totals_t t;
    result_cnt++;
    if (totals_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, d);
      fail_cnt++;
      return;
    end
    t = totals_q.pop_front();
    check_field("particle_count", 64'(t.count), 64'(d[20:0]));
    check_field("sum_vel_x", t.vx, d[84:21]);
    check_field("sum_vel_y", t.vy, d[148:85]);
    check_field("sum_vel_z", t.vz, d[212:149]);
    check_field("total_volume", 64'(t.volume), 64'(d[275:213]));
    check_field("total_mass", 64'(t.mass), 64'(d[338:276]));
    check_field("kinetic_energy", 64'(t.energy), 64'(d[401:339]));
    check_field("peak_speed", 64'(t.peak), 64'(d[433:402]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mask_r = '1; cx_r = '0; cy_r = '0; cz_r = '0; radius_r = '0;
      clear_sums();
      totals_q.delete();
      fail_cnt = 0;
      result_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TYPE_MASK: mask_r = cfg_data;
          REG_CENTER_X:  cx_r = cfg_data;
          REG_CENTER_Y:  cy_r = cfg_data;
          REG_CENTER_Z:  cz_r = cfg_data;
          REG_RADIUS:    radius_r = cfg_data;
          default: ;
        endcase
      end
      // results leave before a new last can be predicted at the same edge
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_particle(s_axis_tdata, s_axis_tlast);
    end
    fails <= fail_cnt;
    pending <= totals_q.size();
    results <= result_cnt;
  end

  final begin
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Particle stream test for particle_stats_reducer: directed extremes, then
// random particle sets under several mask and sphere settings, with bursty
// input, a stalling output side and a separate prediction checker.
// ----------------------------------------------------------------------------
module tb_top import psr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  int fails, pending, results;
  int burst_left = 0;
  int sent = 0;
  int settings_run = 0;
  int idle_cycles = 0;
  int rx_span = 0;
  int rx_mode = 0;
  logic [31:0] cur_cx = '0, cur_cy = '0, cur_cz = '0;

  always #2 clk = ~clk;

  particle_stats_reducer u_dut (.*);

  psr_checker u_checker (.*);

  // output side stall pattern: runs of ready, random, stalled or toggling
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = (rx_mode == 2) ? $urandom_range(1, 150) : $urandom_range(20, 300);
    end
    rx_span--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= 1'b0;
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 255) << 16;
      5: return $urandom_range(0, 32'h0003_ffff);
      default: return $urandom;
    endcase
  endfunction

  // position near the sphere centre half the time
  function automatic logic [31:0] pick_pos(logic [31:0] c);
    if ($urandom_range(0, 1)) return c + 32'($signed($urandom_range(0, 32'h0020_0000))
                                             - 32'sh0010_0000);
    return pick32();
  endfunction

  task automatic send_particle(logic [5:0] ptype, logic [31:0] vx, logic [31:0] vy,
                               logic [31:0] vz, logic [31:0] dens, logic [31:0] vfr,
                               logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, pz, py, px, vfr, dens, vz, vy, vx, ptype};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // wait for every result, then for masked or unfinished work to drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] mask, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] cz, logic [31:0] radius);
    settle();
    write_reg(REG_TYPE_MASK, mask);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, radius);
    cur_cx = cx; cur_cy = cy; cur_cz = cz;
    settings_run++;
  endtask

  task automatic random_sets(int n_items);
    int left, n;
    logic [5:0] ptype;
    left = n_items;
    while (left > 0) begin
      n = $urandom_range(1, 20);
      if (n > left) n = left;
      for (int i = 0; i < n; i++) begin
        ptype = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 32));
        send_particle(ptype, pick32(), pick32(), pick32(), pick32(), pick32(),
                      pick_pos(cur_cx), pick_pos(cur_cy), pick_pos(cur_cz), i == n - 1);
      end
      left -= n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: everything counted, sphere off
    send_particle(6'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_particle(6'd0, 32'h7fff_ffff, 1, 2, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1'b1);
    send_particle(6'd33, 32'h8000_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1'b0);
    send_particle(6'd63, 32'h7fff_ffff, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1'b0);
    send_particle(6'd32, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0);
    send_particle(6'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0002_0000, 32'h0000_8000, 0, 0, 0, 1'b0);
    send_particle(6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);

    // small sphere: surface, just outside, centre, and out-of-range centre offsets
    configure(32'hffff_ffff, 32'h0001_0000, 32'hfff0_0000, 32'h0000_0000, 32'h0010_0000);
    send_particle(6'd5, 32'h0003_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                  32'h0011_0000, 32'hfff0_0000, 0, 1'b0);
    send_particle(6'd6, 32'h0009_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                  32'h0011_0001, 32'hfff0_0000, 0, 1'b0);
    send_particle(6'd7, 32'h0002_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000, 32'hfff0_0000, 0, 1'b1);
    send_particle(6'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    random_sets(250);

    configure(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
    send_particle(6'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3, 3,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    random_sets(250);

    configure(32'h0000_0000, $urandom, $urandom, $urandom, $urandom);
    random_sets(240);

    configure(32'haaaa_aaaa, $urandom, $urandom, $urandom, 32'h0000_0001);
    random_sets(250);

    configure($urandom, $urandom, $urandom, $urandom, $urandom);
    random_sets(250);

    settle();
    repeat (100) @(posedge clk);

    $display("%0d particles sent under %0d register settings, %0d results checked",
             sent, settings_run + 1, results);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
